/* rtl/rmmc_pkg.sv */
// Shared types and constants for the robot mission mode controller.
// Used by rmmc_step, the unit, its checker and testbench; no dependencies.
package rmmc_pkg;

   localparam int unsigned BLOCK_RUN_DEF = 2;
   localparam int unsigned CLEAR_RUN_DEF = 3;

   localparam logic [15:0] DETECT_DWELL_MS = 16'd500;
   localparam logic [31:0] AVOID_MIN_MS    = 32'd500;

   localparam logic [11:0] BLOCK_MM_RST     = 12'd500;
   localparam logic [11:0] COLLECT_MM_RST   = 12'd300;
   localparam logic [11:0] SIDE_MM_RST      = 12'd600;
   localparam logic [11:0] CLEAR_MM_RST     = 12'd800;
   localparam logic [15:0] INIT_TMO_RST     = 16'd3000;
   localparam logic [15:0] APPROACH_TMO_RST = 16'd10000;
   localparam logic [15:0] COLLECT_TMO_RST  = 16'd5000;
   localparam logic [15:0] AVOID_TMO_RST    = 16'd3000;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [2:0] {
      REG_BLOCK_MM     = 3'd0,
      REG_COLLECT_MM   = 3'd1,
      REG_SIDE_MM      = 3'd2,
      REG_CLEAR_MM     = 3'd3,
      REG_INIT_TMO     = 3'd4,
      REG_APPROACH_TMO = 3'd5,
      REG_COLLECT_TMO  = 3'd6,
      REG_AVOID_TMO    = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      MODE_INIT     = 3'd0,
      MODE_SEARCH   = 3'd1,
      MODE_DETECT   = 3'd2,
      MODE_APPROACH = 3'd3,
      MODE_COLLECT  = 3'd4,
      MODE_AVOID    = 3'd5,
      MODE_RETURN   = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      DRIVE_NONE       = 3'd0,
      DRIVE_HOLD       = 3'd1,
      DRIVE_STRAIGHT   = 3'd2,
      DRIVE_SERPENTINE = 3'd3,
      DRIVE_APPROACH   = 3'd4,
      DRIVE_TURN_LEFT  = 3'd5,
      DRIVE_TURN_RIGHT = 3'd6,
      DRIVE_RETURN     = 3'd7
   } drive_type;

   typedef enum logic [1:0] {
      LED_KEEP = 2'd0,
      LED_ON   = 2'd1,
      LED_OFF  = 2'd2
   } led_type;

   typedef enum logic [1:0] {
      COLL_NONE  = 2'd0,
      COLL_START = 2'd1,
      COLL_STOP  = 2'd2
   } coll_type;

   typedef enum logic [1:0] {
      CALIB_NONE   = 2'd0,
      CALIB_START  = 2'd1,
      CALIB_FINISH = 2'd2
   } calib_type;

   localparam logic [1:0] PHASE_RIGHT = 2'd1;
   localparam logic [1:0] PHASE_LEFT  = 2'd3;

   typedef struct packed {
      logic [11:0] block_mm;
      logic [11:0] collect_mm;
      logic [11:0] side_mm;
      logic [11:0] clear_mm;
      logic [15:0] init_tmo;
      logic [15:0] approach_tmo;
      logic [15:0] collect_tmo;
      logic [15:0] avoid_tmo;
   } cfg_type;

   typedef struct packed {
      logic               restart;
      logic [31:0]        now_ms;
      logic [11:0]        front_mm;
      logic [11:0]        left_mm;
      logic [11:0]        right_mm;
      logic               front_ok;
      logic               packet_ready;
      logic               packet_is_trash;
      logic signed [15:0] packet_x;
      logic signed [15:0] packet_y;
      logic [1:0]         cruise_phase;
      logic               tracking_ok;
   } item_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] entry_time;
      logic [15:0] dwell;
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic               mode_changed;
      led_type            led_cmd;
      drive_type          drive_cmd;
      logic               stop_all;
      coll_type           collect_cmd;
      calib_type          calib_cmd;
      logic               packet_taken;
      logic               target_load;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
   } result_type;

endpackage

/* rtl/rmmc_step.sv */
// Per-tick decision logic of the mission mode controller: next state and result.
// Depends on rmmc_pkg.
module rmmc_step #(
   parameter int unsigned BLOCK_RUN = rmmc_pkg::BLOCK_RUN_DEF,
   parameter int unsigned CLEAR_RUN = rmmc_pkg::CLEAR_RUN_DEF,
   parameter int unsigned BW = $clog2(BLOCK_RUN + 1),
   parameter int unsigned CW = $clog2(CLEAR_RUN + 1)
) (
   input  rmmc_pkg::cfg_type    cfg,
   input  rmmc_pkg::item_type   item,
   input  rmmc_pkg::state_type  st,
   input  logic [BW-1:0]        blocked_run,
   input  logic [CW-1:0]        clear_run,
   output rmmc_pkg::state_type  st_next,
   output logic [BW-1:0]        blocked_next,
   output logic [CW-1:0]        clear_next,
   output rmmc_pkg::result_type res
);
   import rmmc_pkg::*;

   localparam logic [BW-1:0] BLOCK_LIM = BW'(BLOCK_RUN);
   localparam logic [CW-1:0] CLEAR_LIM = CW'(CLEAR_RUN);

   logic [31:0]   elapsed;
   logic          timed_out;
   logic          blocked;
   logic          done;
   logic [BW-1:0] blocked_inc;
   logic [CW-1:0] clear_inc;
   state_type     nst;
   result_type    r;

   function automatic state_type enter(input mode_type m, input logic [31:0] now,
                                       input logic [15:0] dwell);
      state_type s;
      s.mode       = m;
      s.entry_time = now;
      s.dwell      = dwell;
      return s;
   endfunction

   assign elapsed     = item.now_ms - st.entry_time;
   assign timed_out   = elapsed >= {16'd0, st.dwell};
   assign blocked     = item.front_mm < cfg.block_mm;
   assign blocked_inc = blocked_run + BW'(1);
   assign clear_inc   = clear_run + CW'(1);

   always_comb begin
      nst          = st;
      blocked_next = blocked_run;
      clear_next   = clear_run;
      done         = 1'b0;
      r            = '0;
      r.led_cmd    = LED_KEEP;
      r.drive_cmd  = DRIVE_NONE;
      r.collect_cmd = COLL_NONE;
      r.calib_cmd  = CALIB_NONE;

      if (item.restart) begin
         nst = enter(MODE_INIT, item.now_ms, cfg.init_tmo);
         r.mode_changed = 1'b1;
         r.calib_cmd = CALIB_START;
      end else begin
         unique case (st.mode)
            MODE_INIT: begin
               r.led_cmd = LED_ON;
               if (timed_out) begin
                  r.calib_cmd = CALIB_FINISH;
                  r.led_cmd = LED_OFF;
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end
            end
            MODE_SEARCH: begin
               if (blocked) begin
                  if (blocked_inc >= BLOCK_LIM) begin
                     blocked_next = '0;
                     nst = enter(MODE_AVOID, item.now_ms, cfg.avoid_tmo);
                     r.mode_changed = 1'b1;
                     done = 1'b1;
                  end else begin
                     blocked_next = blocked_inc;
                  end
               end else begin
                  blocked_next = '0;
               end
               if (!done) begin
                  if (item.packet_ready) begin
                     r.packet_taken = 1'b1;
                     if (item.packet_is_trash) begin
                        blocked_next = '0;
                        r.target_load = 1'b1;
                        r.target_x = item.packet_x;
                        r.target_y = item.packet_y;
                        nst = enter(MODE_DETECT, item.now_ms, DETECT_DWELL_MS);
                        r.mode_changed = 1'b1;
                     end
                  end else if (!item.front_ok) begin
                     r.drive_cmd = DRIVE_HOLD;
                  end else if ((item.cruise_phase == PHASE_RIGHT &&
                                item.right_mm < cfg.side_mm) ||
                               (item.cruise_phase == PHASE_LEFT &&
                                item.left_mm < cfg.side_mm)) begin
                     r.drive_cmd = DRIVE_STRAIGHT;
                  end else begin
                     r.drive_cmd = DRIVE_SERPENTINE;
                  end
               end
            end
            MODE_DETECT: begin
               if (blocked) begin
                  nst = enter(MODE_AVOID, item.now_ms, cfg.avoid_tmo);
                  r.mode_changed = 1'b1;
               end else if (item.packet_ready) begin
                  r.packet_taken = 1'b1;
                  if (item.packet_is_trash) begin
                     r.target_load = 1'b1;
                     r.target_x = item.packet_x;
                     r.target_y = item.packet_y;
                     nst = enter(MODE_APPROACH, item.now_ms, cfg.approach_tmo);
                     r.mode_changed = 1'b1;
                  end
               end else if (timed_out) begin
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end
            end
            MODE_APPROACH: begin
               if (!item.front_ok) begin
                  r.stop_all = 1'b1;
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end else if (item.front_mm < cfg.collect_mm) begin
                  nst = enter(MODE_COLLECT, item.now_ms, cfg.collect_tmo);
                  r.mode_changed = 1'b1;
               end else if (blocked) begin
                  nst = enter(MODE_AVOID, item.now_ms, cfg.avoid_tmo);
                  r.mode_changed = 1'b1;
               end else if (timed_out) begin
                  r.stop_all = 1'b1;
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end else begin
                  if (item.packet_ready) begin
                     r.packet_taken = 1'b1;
                     if (item.packet_is_trash) begin
                        r.target_load = 1'b1;
                        r.target_x = item.packet_x;
                        r.target_y = item.packet_y;
                     end
                  end
                  r.drive_cmd = DRIVE_APPROACH;
                  if (!item.tracking_ok) begin
                     r.stop_all = 1'b1;
                     nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                     r.mode_changed = 1'b1;
                  end
               end
            end
            MODE_COLLECT: begin
               r.collect_cmd = COLL_START;
               if (timed_out) begin
                  r.collect_cmd = COLL_STOP;
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end
            end
            MODE_AVOID: begin
               r.drive_cmd = (item.left_mm > item.right_mm) ? DRIVE_TURN_LEFT
                                                            : DRIVE_TURN_RIGHT;
               if (elapsed > AVOID_MIN_MS) begin
                  if (item.front_mm > cfg.clear_mm) begin
                     if (clear_inc >= CLEAR_LIM) begin
                        r.stop_all = 1'b1;
                        clear_next = '0;
                        nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                        r.mode_changed = 1'b1;
                        done = 1'b1;
                     end else begin
                        clear_next = clear_inc;
                     end
                  end else begin
                     clear_next = '0;
                  end
               end
               if (!done && timed_out) begin
                  r.stop_all = 1'b1;
                  clear_next = '0;
                  nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
                  r.mode_changed = 1'b1;
               end
            end
            MODE_RETURN: begin
               r.drive_cmd = DRIVE_RETURN;
            end
            default: begin
               nst = enter(MODE_SEARCH, item.now_ms, 16'd0);
               r.mode_changed = 1'b1;
            end
         endcase
      end
      r.mode = nst.mode;
   end

   assign st_next = nst;
   assign res     = r;

endmodule

/* rtl/robot_mission_mode_controller_unit.sv */
// Robot mission mode controller: one control tick in, one command item out,
// at one tick per clock cycle while req_tready is high. Each accepted tick is
// decided in the cycle it is accepted; a two-entry output buffer registers its
// result, in the second entry while the first waits, so ticks keep being taken
// while one result waits; req_tready drops only when both entries are full.
// Thresholds and timeouts are to be set through the register port only while no
// tick is in flight; the block does not enforce this. Needs rmmc_pkg, rmmc_step.
module robot_mission_mode_controller_unit #(
   parameter int unsigned BLOCK_RUN = rmmc_pkg::BLOCK_RUN_DEF,
   parameter int unsigned CLEAR_RUN = rmmc_pkg::CLEAR_RUN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // now_ms[31:0], front_mm[43:32], left_mm[55:44], right_mm[67:56], front_ok[68],
   // packet_ready[69], packet_is_trash[70], packet_x[86:71], packet_y[102:87],
   // cruise_phase[104:103], tracking_ok[105], zero pad[111:106]
   input  logic [rmmc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // restart[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mode[2:0], mode_changed[3], led_cmd[5:4], drive_cmd[8:6], stop_all[9],
   // collect_cmd[11:10], calib_cmd[13:12], packet_taken[14], target_load[15],
   // target_x[31:16], target_y[47:32]
   output logic [rmmc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rmmc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rmmc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rmmc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import rmmc_pkg::*;

   localparam int unsigned BW = $clog2(BLOCK_RUN + 1);
   localparam int unsigned CW = $clog2(CLEAR_RUN + 1);

   cfg_type       cfg_ff, cfg_in;
   state_type     st_ff, st_in;
   logic [BW-1:0] blocked_ff, blocked_in;
   logic [CW-1:0] clear_ff, clear_in;
   result_type    res;
   result_type    out_ff, out_in;
   result_type    skid_ff, skid_in;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   item_type      item;
   csr_reg_type   csr_idx;
   logic          csr_wr;
   logic          accept;
   logic          pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_BLOCK_MM:     cfg_in.block_mm     = csr_pwdata[11:0];
            REG_COLLECT_MM:   cfg_in.collect_mm   = csr_pwdata[11:0];
            REG_SIDE_MM:      cfg_in.side_mm      = csr_pwdata[11:0];
            REG_CLEAR_MM:     cfg_in.clear_mm     = csr_pwdata[11:0];
            REG_INIT_TMO:     cfg_in.init_tmo     = csr_pwdata[15:0];
            REG_APPROACH_TMO: cfg_in.approach_tmo = csr_pwdata[15:0];
            REG_COLLECT_TMO:  cfg_in.collect_tmo  = csr_pwdata[15:0];
            REG_AVOID_TMO:    cfg_in.avoid_tmo    = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BLOCK_MM:     csr_prdata = {20'd0, cfg_ff.block_mm};
         REG_COLLECT_MM:   csr_prdata = {20'd0, cfg_ff.collect_mm};
         REG_SIDE_MM:      csr_prdata = {20'd0, cfg_ff.side_mm};
         REG_CLEAR_MM:     csr_prdata = {20'd0, cfg_ff.clear_mm};
         REG_INIT_TMO:     csr_prdata = {16'd0, cfg_ff.init_tmo};
         REG_APPROACH_TMO: csr_prdata = {16'd0, cfg_ff.approach_tmo};
         REG_COLLECT_TMO:  csr_prdata = {16'd0, cfg_ff.collect_tmo};
         REG_AVOID_TMO:    csr_prdata = {16'd0, cfg_ff.avoid_tmo};
         default:          csr_prdata = '0;
      endcase
   end

   assign item.restart         = req_tuser;
   assign item.now_ms          = req_tdata[31:0];
   assign item.front_mm        = req_tdata[43:32];
   assign item.left_mm         = req_tdata[55:44];
   assign item.right_mm        = req_tdata[67:56];
   assign item.front_ok        = req_tdata[68];
   assign item.packet_ready    = req_tdata[69];
   assign item.packet_is_trash = req_tdata[70];
   assign item.packet_x        = req_tdata[86:71];
   assign item.packet_y        = req_tdata[102:87];
   assign item.cruise_phase    = req_tdata[104:103];
   assign item.tracking_ok     = req_tdata[105];

   rmmc_step #(
      .BLOCK_RUN (BLOCK_RUN),
      .CLEAR_RUN (CLEAR_RUN),
      .BW        (BW),
      .CW        (CW)
   ) u_step (
      .cfg          (cfg_ff),
      .item         (item),
      .st           (st_ff),
      .blocked_run  (blocked_ff),
      .clear_run    (clear_ff),
      .st_next      (st_in),
      .blocked_next (blocked_in),
      .clear_next   (clear_in),
      .res          (res)
   );

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_mm     <= BLOCK_MM_RST;
         cfg_ff.collect_mm   <= COLLECT_MM_RST;
         cfg_ff.side_mm      <= SIDE_MM_RST;
         cfg_ff.clear_mm     <= CLEAR_MM_RST;
         cfg_ff.init_tmo     <= INIT_TMO_RST;
         cfg_ff.approach_tmo <= APPROACH_TMO_RST;
         cfg_ff.collect_tmo  <= COLLECT_TMO_RST;
         cfg_ff.avoid_tmo    <= AVOID_TMO_RST;
         st_ff.mode          <= MODE_INIT;
         st_ff.entry_time    <= '0;
         st_ff.dwell         <= INIT_TMO_RST;
         blocked_ff          <= '0;
         clear_ff            <= '0;
         out_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            st_ff      <= st_in;
            blocked_ff <= blocked_in;
            clear_ff   <= clear_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.target_y, out_ff.target_x, out_ff.target_load,
                        out_ff.packet_taken, out_ff.calib_cmd, out_ff.collect_cmd,
                        out_ff.stop_all, out_ff.drive_cmd, out_ff.led_cmd,
                        out_ff.mode_changed, out_ff.mode};

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("second output entry holds an item while the first is empty");

   a_restart_to_init: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (st_ff.mode == MODE_INIT && st_ff.dwell == $past(cfg_ff.init_tmo)))
      else $error("restart item did not put the controller into init");

   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.target_load) |->
         (out_ff.target_x == 16'sd0 && out_ff.target_y == 16'sd0))
      else $error("target coordinates present without a target load");

   a_full_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("accepted item not buffered while the output was stalled");

endmodule

/* sim/rmmc_command_checker.sv */
// Checker for the robot mission mode controller: watches the tick, command and
// register channels, predicts each command item and compares it field by field.
// Depends on rmmc_pkg for field types, codes and register reset values.
`timescale 1ns / 1ps

module rmmc_command_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [rmmc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rmmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rmmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rmmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                            csr_pready,
   output int unsigned                     fail_count,
   output int unsigned                     pending
);
   import rmmc_pkg::*;

   cfg_type     cfg;
   mode_type    md;
   logic [31:0] entry_ms;
   logic [15:0] dwell_ms;
   logic [1:0]  blocked_cnt;
   logic [1:0]  clear_cnt;
   logic [31:0] tick_ms;
   logic        entered;

   result_type  pending_cmds[$];
   result_type  want;
   result_type  predicted;
   item_type    tick;

   task automatic switch_mode(input mode_type m, input logic [15:0] dwell);
      md = m;
      entry_ms = tick_ms;
      dwell_ms = dwell;
      entered = 1'b1;
   endtask

   function automatic logic expired();
      return (tick_ms - entry_ms) >= {16'd0, dwell_ms};
   endfunction

   task automatic mission_step(input item_type t, output result_type r);
      logic [31:0] elapsed;
      logic        done;
      r = result_type'(0);
      tick_ms = t.now_ms;
      entered = 1'b0;
      if (t.restart) begin
         switch_mode(MODE_INIT, cfg.init_tmo);
         r.calib_cmd = CALIB_START;
      end else begin
         case (md)
            MODE_INIT: begin
               r.led_cmd = LED_ON;
               if (expired()) begin
                  r.calib_cmd = CALIB_FINISH;
                  switch_mode(MODE_SEARCH, 16'd0);
                  r.led_cmd = LED_OFF;
               end
            end
            MODE_SEARCH: begin
               if (t.front_mm < cfg.block_mm) begin
                  blocked_cnt = blocked_cnt + 2'd1;
                  if (blocked_cnt >= BLOCK_RUN_DEF) begin
                     blocked_cnt = 2'd0;
                     switch_mode(MODE_AVOID, cfg.avoid_tmo);
                  end
               end else begin
                  blocked_cnt = 2'd0;
               end
               if (md == MODE_SEARCH) begin
                  if (t.packet_ready) begin
                     r.packet_taken = 1'b1;
                     if (t.packet_is_trash) begin
                        blocked_cnt = 2'd0;
                        r.target_load = 1'b1;
                        r.target_x = t.packet_x;
                        r.target_y = t.packet_y;
                        switch_mode(MODE_DETECT, DETECT_DWELL_MS);
                     end
                  end else if (!t.front_ok) begin
                     r.drive_cmd = DRIVE_HOLD;
                  end else if ((t.cruise_phase == PHASE_RIGHT && t.right_mm < cfg.side_mm) ||
                               (t.cruise_phase == PHASE_LEFT && t.left_mm < cfg.side_mm)) begin
                     r.drive_cmd = DRIVE_STRAIGHT;
                  end else begin
                     r.drive_cmd = DRIVE_SERPENTINE;
                  end
               end
            end
            MODE_DETECT: begin
               if (t.front_mm < cfg.block_mm) begin
                  switch_mode(MODE_AVOID, cfg.avoid_tmo);
               end else if (t.packet_ready) begin
                  r.packet_taken = 1'b1;
                  if (t.packet_is_trash) begin
                     r.target_load = 1'b1;
                     r.target_x = t.packet_x;
                     r.target_y = t.packet_y;
                     switch_mode(MODE_APPROACH, cfg.approach_tmo);
                  end
               end else if (expired()) begin
                  switch_mode(MODE_SEARCH, 16'd0);
               end
            end
            MODE_APPROACH: begin
               if (!t.front_ok) begin
                  r.stop_all = 1'b1;
                  switch_mode(MODE_SEARCH, 16'd0);
               end else if (t.front_mm < cfg.collect_mm) begin
                  switch_mode(MODE_COLLECT, cfg.collect_tmo);
               end else if (t.front_mm < cfg.block_mm) begin
                  switch_mode(MODE_AVOID, cfg.avoid_tmo);
               end else if (expired()) begin
                  r.stop_all = 1'b1;
                  switch_mode(MODE_SEARCH, 16'd0);
               end else begin
                  if (t.packet_ready) begin
                     r.packet_taken = 1'b1;
                     if (t.packet_is_trash) begin
                        r.target_load = 1'b1;
                        r.target_x = t.packet_x;
                        r.target_y = t.packet_y;
                     end
                  end
                  r.drive_cmd = DRIVE_APPROACH;
                  if (!t.tracking_ok) begin
                     r.stop_all = 1'b1;
                     switch_mode(MODE_SEARCH, 16'd0);
                  end
               end
            end
            MODE_COLLECT: begin
               r.collect_cmd = COLL_START;
               if (expired()) begin
                  r.collect_cmd = COLL_STOP;
                  switch_mode(MODE_SEARCH, 16'd0);
               end
            end
            MODE_AVOID: begin
               elapsed = tick_ms - entry_ms;
               done = 1'b0;
               r.drive_cmd = (t.left_mm > t.right_mm) ? DRIVE_TURN_LEFT : DRIVE_TURN_RIGHT;
               if (elapsed > AVOID_MIN_MS) begin
                  if (t.front_mm > cfg.clear_mm) begin
                     clear_cnt = clear_cnt + 2'd1;
                     if (clear_cnt >= CLEAR_RUN_DEF) begin
                        r.stop_all = 1'b1;
                        clear_cnt = 2'd0;
                        switch_mode(MODE_SEARCH, 16'd0);
                        done = 1'b1;
                     end
                  end else begin
                     clear_cnt = 2'd0;
                  end
               end
               if (!done && expired()) begin
                  r.stop_all = 1'b1;
                  clear_cnt = 2'd0;
                  switch_mode(MODE_SEARCH, 16'd0);
               end
            end
            MODE_RETURN: begin
               r.drive_cmd = DRIVE_RETURN;
            end
            default: begin
               switch_mode(MODE_SEARCH, 16'd0);
            end
         endcase
      end
      r.mode = md;
      r.mode_changed = entered;
   endtask

   task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
      if (a !== e) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '{BLOCK_MM_RST, COLLECT_MM_RST, SIDE_MM_RST, CLEAR_MM_RST,
                 INIT_TMO_RST, APPROACH_TMO_RST, COLLECT_TMO_RST, AVOID_TMO_RST};
         md = MODE_INIT;
         entry_ms = '0;
         dwell_ms = INIT_TMO_RST;
         blocked_cnt = 2'd0;
         clear_cnt = 2'd0;
         pending_cmds.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_cmds.size() == 0) begin
               fail_count++;
               $display("%0t: command item with none expected, actual %0h",
                        $time, rsp_tdata);
            end else begin
               want = pending_cmds.pop_front();
               cmp_field("mode", 32'(want.mode), 32'(rsp_tdata[2:0]));
               cmp_field("mode_changed", 32'(want.mode_changed), 32'(rsp_tdata[3]));
               cmp_field("led_cmd", 32'(want.led_cmd), 32'(rsp_tdata[5:4]));
               cmp_field("drive_cmd", 32'(want.drive_cmd), 32'(rsp_tdata[8:6]));
               cmp_field("stop_all", 32'(want.stop_all), 32'(rsp_tdata[9]));
               cmp_field("collect_cmd", 32'(want.collect_cmd), 32'(rsp_tdata[11:10]));
               cmp_field("calib_cmd", 32'(want.calib_cmd), 32'(rsp_tdata[13:12]));
               cmp_field("packet_taken", 32'(want.packet_taken), 32'(rsp_tdata[14]));
               cmp_field("target_load", 32'(want.target_load), 32'(rsp_tdata[15]));
               cmp_field("target_x", {16'd0, want.target_x}, {16'd0, rsp_tdata[31:16]});
               cmp_field("target_y", {16'd0, want.target_y}, {16'd0, rsp_tdata[47:32]});
            end
         end
         if (req_tvalid && req_tready) begin
            tick.restart = req_tuser;
            tick.now_ms = req_tdata[31:0];
            tick.front_mm = req_tdata[43:32];
            tick.left_mm = req_tdata[55:44];
            tick.right_mm = req_tdata[67:56];
            tick.front_ok = req_tdata[68];
            tick.packet_ready = req_tdata[69];
            tick.packet_is_trash = req_tdata[70];
            tick.packet_x = req_tdata[86:71];
            tick.packet_y = req_tdata[102:87];
            tick.cruise_phase = req_tdata[104:103];
            tick.tracking_ok = req_tdata[105];
            mission_step(tick, predicted);
            pending_cmds.push_back(predicted);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[4:2]))
               REG_BLOCK_MM:     cfg.block_mm = csr_pwdata[11:0];
               REG_COLLECT_MM:   cfg.collect_mm = csr_pwdata[11:0];
               REG_SIDE_MM:      cfg.side_mm = csr_pwdata[11:0];
               REG_CLEAR_MM:     cfg.clear_mm = csr_pwdata[11:0];
               REG_INIT_TMO:     cfg.init_tmo = csr_pwdata[15:0];
               REG_APPROACH_TMO: cfg.approach_tmo = csr_pwdata[15:0];
               REG_COLLECT_TMO:  cfg.collect_tmo = csr_pwdata[15:0];
               REG_AVOID_TMO:    cfg.avoid_tmo = csr_pwdata[15:0];
               default: ;
            endcase
         end
         pending <= pending_cmds.size();
      end
   end

endmodule

/* sim/robot_mission_mode_controller_unit_tb.sv */
// Testbench top for the robot mission mode controller: drives control ticks,
// register writes and output stalls, and reports the verdict of the checker.
// Depends on rmmc_pkg, robot_mission_mode_controller_unit and rmmc_command_checker.
`timescale 1ns / 1ps

module robot_mission_mode_controller_unit_tb;
   import rmmc_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 228;
   localparam int HOLD_CYCLES  = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           fail_count;
   int unsigned           pending;

   int                    req_idle_pct = 13;
   int                    rsp_idle_pct = 74;
   logic                  hold_req = 1'b0;
   int                    hold_left = 0;
   int                    cycle_count = 0;
   logic [31:0]           now_base = '0;
   cfg_type               cfg;

   robot_mission_mode_controller_unit u_dut (.*);

   rmmc_command_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(input item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.restart;
      req_tdata <= {6'd0, it.tracking_ok, it.cruise_phase, it.packet_y, it.packet_x,
                    it.packet_is_trash, it.packet_ready, it.front_ok, it.right_mm,
                    it.left_mm, it.front_mm, it.now_ms};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input int kind);
      if (kind == 1) begin
         cfg = '0;
      end else if (kind == 3) begin
         cfg = '1;
      end else begin
         cfg.collect_mm = 12'($urandom_range(600, 100));
         cfg.block_mm = 12'(cfg.collect_mm + $urandom_range(400));
         cfg.side_mm = 12'($urandom_range(1500, 200));
         cfg.clear_mm = 12'(cfg.block_mm + $urandom_range(800));
         cfg.init_tmo = 16'($urandom_range(4000));
         cfg.approach_tmo = 16'($urandom_range(12000));
         cfg.collect_tmo = 16'($urandom_range(6000));
         cfg.avoid_tmo = 16'($urandom_range(5000));
      end
      csr_write(REG_BLOCK_MM, 32'(cfg.block_mm));
      csr_write(REG_COLLECT_MM, 32'(cfg.collect_mm));
      csr_write(REG_SIDE_MM, 32'(cfg.side_mm));
      csr_write(REG_CLEAR_MM, 32'(cfg.clear_mm));
      csr_write(REG_INIT_TMO, 32'(cfg.init_tmo));
      csr_write(REG_APPROACH_TMO, 32'(cfg.approach_tmo));
      csr_write(REG_COLLECT_TMO, 32'(cfg.collect_tmo));
      csr_write(REG_AVOID_TMO, 32'(cfg.avoid_tmo));
   endtask

   function automatic item_type quiet(input int unsigned dt);
      item_type it;
      now_base += dt;
      it = '0;
      it.now_ms = now_base;
      it.front_mm = 12'd2000;
      it.left_mm = 12'd2000;
      it.right_mm = 12'd2000;
      it.front_ok = 1'b1;
      it.tracking_ok = 1'b1;
      return it;
   endfunction

   task automatic send_trash();
      item_type it;
      it = quiet(10);
      it.packet_ready = 1'b1;
      it.packet_is_trash = 1'b1;
      it.packet_x = 16'($urandom());
      it.packet_y = 16'($urandom());
      send_item(it);
   endtask

   function automatic logic [11:0] near(input logic [11:0] v);
      int n;
      n = int'(v) + int'($urandom_range(2)) - 1;
      if (n < 0) n = 0;
      if (n > 4095) n = 4095;
      return n[11:0];
   endfunction

   function automatic item_type next_tick();
      item_type it;
      int r;
      r = $urandom_range(99);
      if (r < 60) now_base += $urandom_range(100, 1);
      else if (r < 90) now_base += $urandom_range(700, 101);
      else if (r < 98) now_base += $urandom_range(4000, 701);
      else now_base += $urandom_range(12000, 4001);
      it.restart = ($urandom_range(999) < 15);
      it.now_ms = ($urandom_range(99) == 0) ? $urandom() : now_base;
      r = $urandom_range(99);
      if (r < 25) begin
         it.front_mm = 12'($urandom_range(cfg.block_mm));
      end else if (r < 45) begin
         case ($urandom_range(3))
            0: it.front_mm = near(cfg.block_mm);
            1: it.front_mm = near(cfg.collect_mm);
            2: it.front_mm = near(cfg.clear_mm);
            default: it.front_mm = near(cfg.side_mm);
         endcase
      end else begin
         it.front_mm = 12'($urandom_range(4095));
      end
      it.left_mm = ($urandom_range(99) < 25) ? near(cfg.side_mm) : 12'($urandom_range(4095));
      it.right_mm = ($urandom_range(99) < 25) ? near(cfg.side_mm) : 12'($urandom_range(4095));
      if ($urandom_range(9) == 0) it.right_mm = it.left_mm;
      it.front_ok = ($urandom_range(99) < 92);
      it.packet_ready = ($urandom_range(99) < 25);
      it.packet_is_trash = ($urandom_range(99) < 70);
      it.packet_x = 16'($urandom());
      it.packet_y = 16'($urandom());
      it.cruise_phase = 2'($urandom_range(3));
      it.tracking_ok = ($urandom_range(99) < 93);
      return it;
   endfunction

   initial begin
      item_type it;
      int p;
      int n;
      cfg = '{BLOCK_MM_RST, COLLECT_MM_RST, SIDE_MM_RST, CLEAR_MM_RST,
              INIT_TMO_RST, APPROACH_TMO_RST, COLLECT_TMO_RST, AVOID_TMO_RST};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      it = quiet(100);
      it.front_mm = '0;
      it.left_mm = 12'hFFF;
      it.right_mm = '0;
      send_item(it);
      it = quiet(100);
      it.restart = 1'b1;
      it.packet_ready = 1'b1;
      it.packet_is_trash = 1'b1;
      it.packet_x = 16'sh8000;
      it.packet_y = 16'sh7FFF;
      send_item(it);
      send_item(quiet(3000));
      it = quiet(10);
      it.front_ok = 1'b0;
      send_item(it);
      it = quiet(10);
      it.cruise_phase = PHASE_RIGHT;
      it.right_mm = cfg.side_mm - 12'd1;
      send_item(it);
      it = quiet(10);
      it.cruise_phase = PHASE_LEFT;
      it.left_mm = '0;
      send_item(it);
      it = quiet(10);
      it.cruise_phase = 2'd2;
      it.front_mm = 12'hFFF;
      send_item(it);
      it = quiet(10);
      it.packet_ready = 1'b1;
      it.packet_x = 16'sh7FFF;
      it.packet_y = 16'sh8000;
      send_item(it);
      it = quiet(10);
      it.front_mm = cfg.block_mm - 12'd1;
      send_item(it);
      it = quiet(10);
      it.front_mm = '0;
      send_item(it);
      it = quiet(10);
      it.left_mm = 12'hFFF;
      it.right_mm = '0;
      send_item(it);
      it = quiet(600);
      it.front_mm = cfg.clear_mm + 12'd1;
      send_item(it);
      it = quiet(10);
      it.front_mm = 12'hFFF;
      send_item(it);
      it = quiet(10);
      it.front_mm = cfg.clear_mm + 12'd1;
      send_item(it);
      send_trash();
      send_trash();
      send_trash();
      it = quiet(10);
      it.tracking_ok = 1'b0;
      send_item(it);
      send_trash();
      send_item(quiet(600));
      send_trash();
      send_trash();
      it = quiet(10);
      it.front_mm = cfg.collect_mm - 12'd1;
      send_item(it);
      send_item(quiet(5000));
      drain();

      for (p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            req_idle_pct = 74;
            rsp_idle_pct = 13;
         end
         if (p == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p == 4) now_base = 32'hFFFF_FFFF - $urandom_range(20000);
         if (p != 0) apply_settings(p);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 6 && n == 60) hold_req = 1'b1;
            if (p == 6 && n == 120) drain();
            send_item(next_tick());
         end
         drain();
      end

      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
